// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the keyboard velocity block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define KVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen outside reset
`define KVC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- sv/kvc_pkg.sv -----
// ----------------------------------------------------------------------------
// kvc_pkg
// Types, key codes and widths shared by the keyboard velocity command block.
// ----------------------------------------------------------------------------
package kvc_pkg;

    // Field widths
    localparam int KEY_W      = 8;
    localparam int LIN_W      = 12;
    localparam int ANG_W      = 10;
    localparam int LSTEP_W    = 11;
    localparam int ASTEP_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Shared shift/subtract unit sizing
    localparam int SQ_W       = 24;          // sum of squares, also product
    localparam int ROOT_W     = 12;          // root and quotient width
    localparam int REM_W      = ROOT_W + 3;  // partial remainder
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = SQ_W;
    localparam int CNT_W      = 5;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_ESC      = 8'h1B;
    localparam logic [KEY_W-1:0] KEY_BRACKET  = 8'h5B;  // '['
    localparam logic [KEY_W-1:0] KEY_UP       = 8'h41;  // 'A'
    localparam logic [KEY_W-1:0] KEY_DOWN     = 8'h42;  // 'B'
    localparam logic [KEY_W-1:0] KEY_RIGHT    = 8'h43;  // 'C'
    localparam logic [KEY_W-1:0] KEY_LEFT     = 8'h44;  // 'D'
    localparam logic [KEY_W-1:0] KEY_ROT_R_LO = 8'h72;  // 'r'
    localparam logic [KEY_W-1:0] KEY_ROT_R_UP = 8'h52;  // 'R'
    localparam logic [KEY_W-1:0] KEY_ROT_L_LO = 8'h6C;  // 'l'
    localparam logic [KEY_W-1:0] KEY_ROT_L_UP = 8'h4C;  // 'L'
    localparam logic [KEY_W-1:0] KEY_BRAKE_LO = 8'h62;  // 'b'
    localparam logic [KEY_W-1:0] KEY_BRAKE_UP = 8'h42;  // 'B'
    localparam logic [KEY_W-1:0] KEY_CTRL_C   = 8'h03;

    // Escape sequence tracking
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_SECOND
    } t_seq_phase;

    // Accumulator update selected by a key
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_FWD,
        ACT_BACK,
        ACT_RIGHT,
        ACT_LEFT,
        ACT_ROT_DN,
        ACT_ROT_UP,
        ACT_CLEAR
    } t_act;

    // Decoder result for one key byte
    typedef struct packed {
        t_act       act;
        logic       hit;      // recognised key, emit a result
        logic       settle;   // key completed, clamp and scale
        t_seq_phase phase;
        logic       bracket;
        logic       halt;
    } t_key_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN_STEP,
        CFG_ANG_STEP,
        CFG_LIN_LIMIT,
        CFG_ANG_LIMIT
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSQX,
        ST_MSQY,
        ST_SQRT,
        ST_CHK,
        ST_MULX,
        ST_DIVX,
        ST_MULY,
        ST_DIVY,
        ST_WRY,
        ST_FIN
    } t_state;

    // Control to the shared shift/subtract unit
    typedef struct packed {
        logic load;
        logic step;
        logic sqrt_mode;
    } t_iter_cmd;

endpackage

// ----- sv/keyboard_velocity_command.sv -----
// ----------------------------------------------------------------------------
// keyboard_velocity_command
// Keyboard teleop: key bytes step three fixed point velocity accumulators,
// which are clamped per axis and scaled back to the planar speed limit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  input   | in        | i_in_valid / o_in_stall   | i_key_byte
//  output  | out       | o_out_valid / i_out_stall | o_lin_x, o_lin_y, o_ang_z
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A byte that completes no key leaves the block idle. A completed key runs
//  12 square root steps, and two 24-step divides when the planar speed is
//  scaled, all through the one shift/subtract unit in kvc_iter. o_in_stall is
//  high while a key is worked on and while a result waits for a full output
//  register. Reset is synchronous, active low; after Ctrl-C bytes are taken
//  and dropped until reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyboard_velocity_command #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // key input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [kvc_pkg::KEY_W-1:0]             i_key_byte,
    // velocity output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [kvc_pkg::LIN_W-1:0]      o_lin_x,
    output logic signed [kvc_pkg::LIN_W-1:0]      o_lin_y,
    output logic signed [kvc_pkg::ANG_W-1:0]      o_ang_z,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [kvc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [kvc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import kvc_pkg::*;

    localparam int SUM_W = LIN_W + 1;
    localparam logic [LSTEP_W-1:0] LinRst =
        LSTEP_W'((5 << FRAC_BITS) & ((1 << LSTEP_W) - 1));
    localparam logic [ASTEP_W-1:0] AngRst =
        ASTEP_W'((1 << FRAC_BITS) & ((1 << ASTEP_W) - 1));

    // symmetric clamp on a widened sum
    function automatic logic signed [SUM_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] res;
        res = v;
        if (v > lim) begin
            res = lim;
        end else if (v < -lim) begin
            res = -lim;
        end
        return res;
    endfunction

    // registers
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [LSTEP_W-1:0]        r_lin_step, r_lin_limit;
    logic [ASTEP_W-1:0]        r_ang_step, r_ang_limit;
    logic signed [LIN_W-1:0]   r_vel_x, n_vel_x;
    logic signed [LIN_W-1:0]   r_vel_y, n_vel_y;
    logic signed [ANG_W-1:0]   r_rot_z, n_rot_z;
    t_seq_phase                r_phase, n_phase;
    logic                      r_bracket, n_bracket;
    logic                      r_halted, n_halted;
    logic                      r_hit, n_hit;
    logic [SQ_W-1:0]           r_acc, n_acc;
    logic [ROOT_W-1:0]         r_mag, n_mag;
    logic                      r_out_valid;
    logic signed [LIN_W-1:0]   r_out_x, r_out_y;
    logic signed [ANG_W-1:0]   r_out_z;

    // combinational
    t_key_cmd                  kcmd;
    t_iter_cmd                 icmd;
    logic                      in_fire;
    logic                      out_free;
    logic                      load_out;
    logic signed [SUM_W-1:0]   sx, sy, sz;
    logic signed [SUM_W-1:0]   lim_l, lim_a, stp_l, stp_a;
    logic signed [SUM_W-1:0]   cx, cy, cz;
    logic [ROOT_W-1:0]         ax, ay;
    logic [ROOT_W-1:0]         mul_a, mul_b;
    logic [SQ_W-1:0]           prod;
    logic [SQ_W-1:0]           iter_src;
    logic [ROOT_W-1:0]         iter_res;
    logic signed [LIN_W-1:0]   q_pos, q_x, q_y;

    // key decoder
    kvc_decode u_decode (
        .i_key     (i_key_byte),
        .i_phase   (r_phase),
        .i_bracket (r_bracket),
        .o_cmd     (kcmd)
    );

    // shared root / divide unit
    kvc_iter u_iter (
        .i_clk     (i_clk),
        .i_cmd     (icmd),
        .i_src     (iter_src),
        .i_divisor (r_mag),
        .o_result  (iter_res)
    );

    assign in_fire     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // step and clamp of the accumulators for the decoded key
    always_comb begin
        lim_l = SUM_W'(r_lin_limit);
        lim_a = SUM_W'(r_ang_limit);
        stp_l = SUM_W'(r_lin_step);
        stp_a = SUM_W'(r_ang_step);
        sx = {r_vel_x[LIN_W-1], r_vel_x};
        sy = {r_vel_y[LIN_W-1], r_vel_y};
        sz = SUM_W'(r_rot_z);
        case (kcmd.act)
            ACT_FWD:    sx = sx + stp_l;
            ACT_BACK:   sx = sx - stp_l;
            ACT_RIGHT:  sy = sy - stp_l;
            ACT_LEFT:   sy = sy + stp_l;
            ACT_ROT_DN: sz = sz - stp_a;
            ACT_ROT_UP: sz = sz + stp_a;
            ACT_CLEAR: begin
                sx = '0;
                sy = '0;
                sz = '0;
            end
            default: begin
                sx = sx;
            end
        endcase
        cx = clamp_sym(sx, lim_l);
        cy = clamp_sym(sy, lim_l);
        cz = clamp_sym(sz, lim_a);
    end

    // magnitudes, shared multiplier, signed quotients
    assign ax    = r_vel_x[LIN_W-1] ? ROOT_W'(-r_vel_x) : ROOT_W'(r_vel_x);
    assign ay    = r_vel_y[LIN_W-1] ? ROOT_W'(-r_vel_y) : ROOT_W'(r_vel_y);
    assign prod  = mul_a * mul_b;
    assign q_pos = signed'(iter_res);
    assign q_x   = r_vel_x[LIN_W-1] ? -q_pos : q_pos;
    assign q_y   = r_vel_y[LIN_W-1] ? -q_pos : q_pos;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_vel_x   = r_vel_x;
        n_vel_y   = r_vel_y;
        n_rot_z   = r_rot_z;
        n_phase   = r_phase;
        n_bracket = r_bracket;
        n_halted  = r_halted;
        n_hit     = r_hit;
        n_acc     = r_acc;
        n_mag     = r_mag;
        icmd      = '0;
        iter_src  = prod;
        mul_a     = ax;
        mul_b     = ax;
        load_out  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && !r_halted) begin
                    n_phase   = kcmd.phase;
                    n_bracket = kcmd.bracket;
                    n_halted  = kcmd.halt;
                    n_hit     = kcmd.hit;
                    if (kcmd.settle) begin
                        n_vel_x = cx[LIN_W-1:0];
                        n_vel_y = cy[LIN_W-1:0];
                        n_rot_z = cz[ANG_W-1:0];
                        n_state = ST_MSQX;
                    end
                end
            end
            ST_MSQX: begin
                n_acc   = prod;
                n_state = ST_MSQY;
            end
            // x^2 + y^2 goes straight into the root unit
            ST_MSQY: begin
                mul_a     = ay;
                mul_b     = ay;
                iter_src  = r_acc + prod;
                icmd.load = 1'b1;
                n_cnt     = CNT_W'(SQRT_STEPS - 1);
                n_state   = ST_SQRT;
            end
            ST_SQRT: begin
                icmd.step      = 1'b1;
                icmd.sqrt_mode = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_CHK;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_CHK: begin
                n_mag = iter_res;
                if (iter_res > {1'b0, r_lin_limit}) begin
                    n_state = ST_MULX;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_MULX: begin
                mul_b     = {1'b0, r_lin_limit};
                icmd.load = 1'b1;
                n_cnt     = CNT_W'(DIV_STEPS - 1);
                n_state   = ST_DIVX;
            end
            ST_DIVX: begin
                icmd.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_MULY;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_MULY: begin
                n_vel_x   = q_x;
                mul_a     = ay;
                mul_b     = {1'b0, r_lin_limit};
                icmd.load = 1'b1;
                n_cnt     = CNT_W'(DIV_STEPS - 1);
                n_state   = ST_DIVY;
            end
            ST_DIVY: begin
                icmd.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_WRY;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_WRY: begin
                n_vel_y = q_y;
                n_state = ST_FIN;
            end
            // hold the result until the output register is free; no result without a hit
            ST_FIN: begin
                if (!r_hit) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_vel_x   <= '0;
            r_vel_y   <= '0;
            r_rot_z   <= '0;
            r_phase   <= PH_IDLE;
            r_bracket <= 1'b0;
            r_halted  <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_vel_x   <= n_vel_x;
            r_vel_y   <= n_vel_y;
            r_rot_z   <= n_rot_z;
            r_phase   <= n_phase;
            r_bracket <= n_bracket;
            r_halted  <= n_halted;
            r_hit     <= n_hit;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_mag <= n_mag;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_step  <= LinRst;
            r_ang_step  <= AngRst;
            r_lin_limit <= LinRst;
            r_ang_limit <= AngRst;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LIN_STEP:  r_lin_step  <= i_cfg_data;
                CFG_ANG_STEP:  r_ang_step  <= i_cfg_data[ASTEP_W-1:0];
                CFG_LIN_LIMIT: r_lin_limit <= i_cfg_data;
                CFG_ANG_LIMIT: r_ang_limit <= i_cfg_data[ASTEP_W-1:0];
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_x <= r_vel_x;
            r_out_y <= r_vel_y;
            r_out_z <= r_rot_z;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lin_x     = r_out_x;
    assign o_lin_y     = r_out_y;
    assign o_ang_z     = r_out_z;

    // checks
    `KVC_ASSERT(a_out_from_fin, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN), "result loaded outside FIN")
    `KVC_ASSERT_NEVER(a_halt_idle, i_clk, i_rst_n,
        r_halted && (r_state != ST_IDLE), "work in progress while halted")
    `KVC_ASSERT(a_div_nonzero, i_clk, i_rst_n,
        (r_state == ST_MULX) |-> (r_mag != '0), "divide by zero magnitude")

endmodule

// ----- sv/kvc_decode.sv -----
// ----------------------------------------------------------------------------
// kvc_decode
// Key byte decoder: escape sequence tracking and accumulator action select.
// ----------------------------------------------------------------------------
module kvc_decode (
    input  logic [kvc_pkg::KEY_W-1:0] i_key,
    input  kvc_pkg::t_seq_phase       i_phase,
    input  logic                      i_bracket,
    output kvc_pkg::t_key_cmd         o_cmd
);
    import kvc_pkg::*;

    always_comb begin
        o_cmd.act     = ACT_NONE;
        o_cmd.hit     = 1'b0;
        o_cmd.settle  = 1'b0;
        o_cmd.phase   = i_phase;
        o_cmd.bracket = i_bracket;
        o_cmd.halt    = 1'b0;

        unique case (i_phase)
            // first byte after ESC: only remember whether it was '['
            PH_ESC: begin
                o_cmd.phase   = PH_SECOND;
                o_cmd.bracket = (i_key == KEY_BRACKET);
            end
            // second byte completes the sequence, arrows only after '['
            PH_SECOND: begin
                o_cmd.phase   = PH_IDLE;
                o_cmd.bracket = 1'b0;
                o_cmd.settle  = 1'b1;
                if (i_bracket) begin
                    unique case (i_key)
                        KEY_UP: begin
                            o_cmd.act = ACT_FWD;
                            o_cmd.hit = 1'b1;
                        end
                        KEY_DOWN: begin
                            o_cmd.act = ACT_BACK;
                            o_cmd.hit = 1'b1;
                        end
                        KEY_RIGHT: begin
                            o_cmd.act = ACT_RIGHT;
                            o_cmd.hit = 1'b1;
                        end
                        KEY_LEFT: begin
                            o_cmd.act = ACT_LEFT;
                            o_cmd.hit = 1'b1;
                        end
                        default: begin
                            o_cmd.act = ACT_NONE;
                        end
                    endcase
                end
            end
            // plain keys
            default: begin
                unique case (i_key) inside
                    KEY_ESC: begin
                        o_cmd.phase   = PH_ESC;
                        o_cmd.bracket = 1'b0;
                    end
                    KEY_ROT_R_LO, KEY_ROT_R_UP: begin
                        o_cmd.act    = ACT_ROT_DN;
                        o_cmd.hit    = 1'b1;
                        o_cmd.settle = 1'b1;
                    end
                    KEY_ROT_L_LO, KEY_ROT_L_UP: begin
                        o_cmd.act    = ACT_ROT_UP;
                        o_cmd.hit    = 1'b1;
                        o_cmd.settle = 1'b1;
                    end
                    KEY_BRAKE_LO, KEY_BRAKE_UP: begin
                        o_cmd.act    = ACT_CLEAR;
                        o_cmd.hit    = 1'b1;
                        o_cmd.settle = 1'b1;
                    end
                    KEY_CTRL_C: begin
                        o_cmd.halt = 1'b1;
                    end
                    // unknown key still clamps and scales
                    default: begin
                        o_cmd.settle = 1'b1;
                    end
                endcase
            end
        endcase
    end

endmodule

// ----- sv/kvc_iter.sv -----
// ----------------------------------------------------------------------------
// kvc_iter
// Shared shift/subtract unit: one root bit or one quotient bit per step.
// ----------------------------------------------------------------------------
module kvc_iter (
    input  logic                       i_clk,
    input  kvc_pkg::t_iter_cmd         i_cmd,
    input  logic [kvc_pkg::SQ_W-1:0]   i_src,
    input  logic [kvc_pkg::ROOT_W-1:0] i_divisor,
    output logic [kvc_pkg::ROOT_W-1:0] o_result
);
    import kvc_pkg::*;

    logic [SQ_W-1:0]   r_src, n_src;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_res, n_res;
    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              ge;

    // trial subtract: sqrt brings in two bits against 4*root+1,
    // divide brings in one bit against the divisor
    always_comb begin
        if (i_cmd.sqrt_mode) begin
            shifted = {r_rem[REM_W-3:0], r_src[SQ_W-1 -: 2]};
            trial   = {1'b0, r_res, 2'b01};
        end else begin
            shifted = {r_rem[REM_W-2:0], r_src[SQ_W-1]};
            trial   = REM_W'(i_divisor);
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = ~diff[REM_W];
    end

    // next state of the unit
    always_comb begin
        n_src = r_src;
        n_rem = r_rem;
        n_res = r_res;
        if (i_cmd.load) begin
            n_src = i_src;
            n_rem = '0;
            n_res = '0;
        end else if (i_cmd.step) begin
            n_rem = ge ? diff[REM_W-1:0] : shifted;
            n_res = {r_res[ROOT_W-2:0], ge};
            n_src = i_cmd.sqrt_mode ? {r_src[SQ_W-3:0], 2'b00}
                                    : {r_src[SQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_rem <= n_rem;
        r_res <= n_res;
    end

    assign o_result = r_res;

endmodule

// ----- bench/tb_keyboard_velocity_command.sv -----
// ----------------------------------------------------------------------------
// tb_keyboard_velocity_command
// Self-checking bench for the keyboard velocity block. Key bytes go in from a
// backlog through a stalling driver. An in-bench model of the accumulators,
// escape sequences, clamps and planar scaling predicts each velocity triple.
// A monitor compares the triples field by field. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_keyboard_velocity_command;
    import kvc_pkg::*;

    localparam int FRAC_BITS      = 8;
    localparam int IDLE_PCT       = 13;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int QUIET_LIMIT    = 3000;

    typedef struct {
        logic signed [LIN_W-1:0] lin_x;
        logic signed [LIN_W-1:0] lin_y;
        logic signed [ANG_W-1:0] ang_z;
    } t_vel_triple;

    // DUT connections
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          o_in_stall;
    logic [KEY_W-1:0]              key_byte  = '0;
    logic                          o_out_valid;
    logic                          out_stall = 1'b0;
    logic signed [LIN_W-1:0]       o_lin_x;
    logic signed [LIN_W-1:0]       o_lin_y;
    logic signed [ANG_W-1:0]       o_ang_z;
    logic                          cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;

    // Stimulus and expectation stores
    logic [KEY_W-1:0]              key_backlog[$];
    t_vel_triple                   pending_velocities[$];
    t_vel_triple                   drv_cmd;
    t_vel_triple                   mon_exp;

    // Run control
    bit                            calm      = 1'b0;
    int                            hold_req  = 0;
    int                            hold_done = 0;
    int                            hold_left = 0;
    int                            errors    = 0;
    int                            quiet_cycles = 0;

    // Model state and registers
    logic signed [LIN_W-1:0]       vx_model = '0;
    logic signed [LIN_W-1:0]       vy_model = '0;
    logic signed [ANG_W-1:0]       rz_model = '0;
    t_seq_phase                    phase_model = PH_IDLE;
    bit                            bracket_model = 1'b0;
    bit                            halted_model  = 1'b0;
    logic [LSTEP_W-1:0]            lin_step_cfg  = LSTEP_W'(5 << FRAC_BITS);
    logic [ASTEP_W-1:0]            ang_step_cfg  = ASTEP_W'(1 << FRAC_BITS);
    logic [LSTEP_W-1:0]            lin_limit_cfg = LSTEP_W'(5 << FRAC_BITS);
    logic [ASTEP_W-1:0]            ang_limit_cfg = ASTEP_W'(1 << FRAC_BITS);

    keyboard_velocity_command #(
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_key_byte  (key_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_lin_x     (o_lin_x),
        .o_lin_y     (o_lin_y),
        .o_ang_z     (o_ang_z),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Symmetric clamp to +/- lim
    function automatic int clamp_sym(input int v, input int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Scale one axis by lim/mag, truncating toward zero
    function automatic int scale_axis(input int v, input int lim, input int mag);
        int a;
        int s;
        a = (v < 0) ? -v : v;
        s = (a * lim) / mag;
        return (v < 0) ? -s : s;
    endfunction

    // Apply one key byte to the model; returns 1 when a triple is emitted
    function automatic bit advance_teleop(input logic [KEY_W-1:0] key,
                                          output t_vel_triple cmd);
        int x;
        int y;
        int z;
        int ls;
        int rot_step;
        int lim;
        int sq;
        int mag;
        int b;
        bit hit;
        x        = vx_model;
        y        = vy_model;
        z        = rz_model;
        ls       = lin_step_cfg;
        rot_step = ang_step_cfg;
        lim      = lin_limit_cfg;
        hit      = 1'b0;
        cmd      = '{lin_x: '0, lin_y: '0, ang_z: '0};
        if (halted_model) return 1'b0;
        // first byte after ESC only records the bracket
        if (phase_model == PH_ESC) begin
            bracket_model = (key == KEY_BRACKET);
            phase_model   = PH_SECOND;
            return 1'b0;
        end
        if (phase_model == PH_SECOND) begin
            phase_model = PH_IDLE;
            if (bracket_model) begin
                case (key)
                    KEY_UP:    begin x += ls; hit = 1'b1; end
                    KEY_DOWN:  begin x -= ls; hit = 1'b1; end
                    KEY_RIGHT: begin y -= ls; hit = 1'b1; end
                    KEY_LEFT:  begin y += ls; hit = 1'b1; end
                    default: ;
                endcase
            end
            bracket_model = 1'b0;
        end else if (key == KEY_ESC) begin
            phase_model   = PH_ESC;
            bracket_model = 1'b0;
            return 1'b0;
        end else if (key == KEY_ROT_R_LO || key == KEY_ROT_R_UP) begin
            z -= rot_step;
            hit = 1'b1;
        end else if (key == KEY_ROT_L_LO || key == KEY_ROT_L_UP) begin
            z += rot_step;
            hit = 1'b1;
        end else if (key == KEY_BRAKE_LO || key == KEY_BRAKE_UP) begin
            x = 0;
            y = 0;
            z = 0;
            hit = 1'b1;
        end else if (key == KEY_CTRL_C) begin
            halted_model = 1'b1;
            return 1'b0;
        end
        // per-axis clamp, then pull planar speed back under the limit
        x  = clamp_sym(x, lim);
        y  = clamp_sym(y, lim);
        z  = clamp_sym(z, ang_limit_cfg);
        sq = x * x + y * y;
        mag = 0;
        for (b = 15; b >= 0; b--) begin
            if ((mag | (1 << b)) * (mag | (1 << b)) <= sq) mag |= (1 << b);
        end
        if (mag > lim) begin
            x = scale_axis(x, lim, mag);
            y = scale_axis(y, lim, mag);
        end
        vx_model  = LIN_W'(x);
        vy_model  = LIN_W'(y);
        rz_model  = ANG_W'(z);
        cmd.lin_x = vx_model;
        cmd.lin_y = vy_model;
        cmd.ang_z = rz_model;
        return hit;
    endfunction

    // Key driver: pops the backlog, holds the byte while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                if (advance_teleop(key_byte, drv_cmd)) pending_velocities.push_back(drv_cmd);
            end
            if (in_valid && o_in_stall) begin
                // stalled transaction stays put
            end else if (key_backlog.size() != 0 &&
                         (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_valid <= 1'b1;
                key_byte <= key_backlog.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Velocity monitor and output stall generator
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (pending_velocities.size() == 0) begin
                    $error("velocity triple with none expected: %0d %0d %0d",
                           o_lin_x, o_lin_y, o_ang_z);
                    errors++;
                end else begin
                    mon_exp = pending_velocities.pop_front();
                    if (o_lin_x !== mon_exp.lin_x) begin
                        $error("lin_x: expected %0d, got %0d", mon_exp.lin_x, o_lin_x);
                        errors++;
                    end
                    if (o_lin_y !== mon_exp.lin_y) begin
                        $error("lin_y: expected %0d, got %0d", mon_exp.lin_y, o_lin_y);
                        errors++;
                    end
                    if (o_ang_z !== mon_exp.ang_z) begin
                        $error("ang_z: expected %0d, got %0d", mon_exp.ang_z, o_ang_z);
                        errors++;
                    end
                end
            end
            // long hold-off on request, else random stalls
            if (hold_req != hold_done) begin
                hold_left = HOLDOFF_CYCLES;
                hold_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL keyboard_velocity_command");
                $finish;
            end
        end
    end

    // Register write; model copy updated on acceptance
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LIN_STEP:  lin_step_cfg  = data[LSTEP_W-1:0];
            CFG_ANG_STEP:  ang_step_cfg  = data[ASTEP_W-1:0];
            CFG_LIN_LIMIT: lin_limit_cfg = data[LSTEP_W-1:0];
            CFG_ANG_LIMIT: ang_limit_cfg = data[ASTEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] lstep, astep, llim, alim);
        cfg_write(CFG_LIN_STEP, lstep);
        cfg_write(CFG_ANG_STEP, astep);
        cfg_write(CFG_LIN_LIMIT, llim);
        cfg_write(CFG_ANG_LIMIT, alim);
    endtask

    // Wait until every byte is taken and every triple has come back
    task automatic drain_block();
        while (key_backlog.size() != 0 || in_valid || pending_velocities.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random key traffic, mostly complete commands, some noise and bad sequences
    task automatic queue_random_keys(input int n);
        int count;
        int r;
        logic [KEY_W-1:0] k;
        count = 0;
        while (count < n) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                case ($urandom_range(0, 3))
                    0: k = KEY_UP;
                    1: k = KEY_DOWN;
                    2: k = KEY_RIGHT;
                    default: k = KEY_LEFT;
                endcase
                key_backlog.push_back(KEY_ESC);
                key_backlog.push_back(KEY_BRACKET);
                key_backlog.push_back(k);
                count += 3;
            end else if (r < 65) begin
                case ($urandom_range(0, 3))
                    0: k = KEY_ROT_R_LO;
                    1: k = KEY_ROT_R_UP;
                    2: k = KEY_ROT_L_LO;
                    default: k = KEY_ROT_L_UP;
                endcase
                key_backlog.push_back(k);
                count++;
            end else if (r < 72) begin
                key_backlog.push_back($urandom_range(0, 1) ? KEY_BRAKE_LO : KEY_BRAKE_UP);
                count++;
            end else if (r < 82) begin
                // stray byte; never ESC or Ctrl-C at top level
                do k = KEY_W'($urandom_range(0, 255)); while (k == KEY_ESC || k == KEY_CTRL_C);
                key_backlog.push_back(k);
                count++;
            end else if (r < 90) begin
                key_backlog.push_back(KEY_ESC);
                key_backlog.push_back(KEY_W'($urandom_range(0, 255)));
                key_backlog.push_back(KEY_W'($urandom_range(0, 255)));
                count += 3;
            end else begin
                key_backlog.push_back(KEY_ESC);
                key_backlog.push_back(KEY_BRACKET);
                key_backlog.push_back(KEY_W'($urandom_range(0, 255)));
                count += 3;
            end
        end
    endtask

    // Phase sequencer
    initial begin
        int p;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: each key, clamps, planar scaling, odd sequences
        key_backlog = '{KEY_ROT_L_LO, KEY_ROT_L_UP, KEY_ROT_R_LO, KEY_ROT_R_UP,
                        KEY_ESC, KEY_BRACKET, KEY_UP,
                        KEY_ESC, KEY_BRACKET, KEY_LEFT,
                        KEY_ESC, KEY_BRACKET, KEY_DOWN,
                        KEY_ESC, KEY_BRACKET, KEY_RIGHT,
                        KEY_BRAKE_LO, KEY_BRAKE_UP,
                        KEY_ESC, KEY_CTRL_C, KEY_UP,
                        KEY_ESC, KEY_ESC, KEY_BRACKET,
                        KEY_UP, 8'hFF, 8'h00};
        drain_block();

        // Long output hold-off while keys keep coming
        hold_req <= hold_req + 1;
        queue_random_keys(150);
        drain_block();

        // Registers at their top codes, beyond nominal range
        set_config(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
        queue_random_keys(140);
        key_backlog.push_back(KEY_ESC);
        key_backlog.push_back(KEY_BRACKET);
        key_backlog.push_back(KEY_UP);
        key_backlog.push_back(KEY_ESC);
        key_backlog.push_back(KEY_BRACKET);
        key_backlog.push_back(KEY_LEFT);
        key_backlog.push_back(KEY_ROT_L_LO);
        drain_block();

        // Lowered limits: unknown keys must still clamp and scale
        set_config(11'd800, 11'd100, 11'd300, 11'd40);
        key_backlog.push_back(8'h7A);
        key_backlog.push_back(8'h7F);
        key_backlog.push_back(KEY_ROT_R_LO);
        queue_random_keys(150);
        drain_block();

        // Zero steps and limits
        set_config('0, '0, '0, '0);
        key_backlog.push_back(KEY_ROT_L_LO);
        key_backlog.push_back(KEY_ESC);
        key_backlog.push_back(KEY_BRACKET);
        key_backlog.push_back(KEY_UP);
        key_backlog.push_back(KEY_BRAKE_LO);
        queue_random_keys(60);
        drain_block();

        // Nominal settings, no idling on either side
        set_config(11'd1280, 11'd256, 11'd1280, 11'd256);
        calm <= 1'b1;
        queue_random_keys(200);
        drain_block();
        calm <= 1'b0;

        // Random settings
        for (p = 0; p < 3; p++) begin
            set_config(CFG_DATA_W'($urandom_range(0, 2047)),
                       CFG_DATA_W'($urandom_range(0, 2047)),
                       CFG_DATA_W'($urandom_range(0, 2047)),
                       CFG_DATA_W'($urandom_range(0, 2047)));
            queue_random_keys(140);
            drain_block();
        end

        // Ctrl-C at top level halts; later bytes draw no result
        key_backlog.push_back(KEY_ROT_L_LO);
        key_backlog.push_back(KEY_CTRL_C);
        key_backlog.push_back(KEY_ESC);
        key_backlog.push_back(KEY_BRACKET);
        key_backlog.push_back(KEY_UP);
        key_backlog.push_back(KEY_BRAKE_LO);
        for (p = 0; p < 8; p++) key_backlog.push_back(KEY_W'($urandom_range(0, 255)));
        drain_block();

        if (errors == 0 && pending_velocities.size() == 0) begin
            $display("PASS keyboard_velocity_command");
        end else begin
            $display("FAIL keyboard_velocity_command");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/kvc_pkg.sv
sv/kvc_decode.sv
sv/kvc_iter.sv
sv/keyboard_velocity_command.sv
bench/tb_keyboard_velocity_command.sv
